@@ sv/ilr_pkg.sv @@
// Shared types, codes and widths of the ILOC line recognizer.
// Used by the step logic, the top level and the port checker; depends on nothing.
`default_nettype none

package ilr_pkg;

    localparam int VALUE_BITS = 32;
    localparam int LINE_BITS  = 20;
    localparam int REG_BITS   = VALUE_BITS - 1;
    localparam int COUNT_BITS = 20;

    localparam int IN_DATA_BITS  = ((REG_BITS + LINE_BITS + 7) / 8) * 8;
    localparam int IN_USER_BITS  = 7;
    localparam int OUT_DATA_BITS =
        ((LINE_BITS + 4 + 3 * VALUE_BITS + COUNT_BITS + REG_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // token categories
    localparam logic [3:0] CAT_MEMOP    = 4'd0;
    localparam logic [3:0] CAT_LOADI    = 4'd1;
    localparam logic [3:0] CAT_ARITH    = 4'd2;
    localparam logic [3:0] CAT_OUTPUT   = 4'd3;
    localparam logic [3:0] CAT_NOP      = 4'd4;
    localparam logic [3:0] CAT_CONST    = 4'd5;
    localparam logic [3:0] CAT_REGISTER = 4'd6;
    localparam logic [3:0] CAT_COMMA    = 4'd7;
    localparam logic [3:0] CAT_ARROW    = 4'd8;
    localparam logic [3:0] CAT_EOF      = 4'd9;
    localparam logic [3:0] CAT_NEWLINE  = 4'd10;

    localparam logic [2:0] VAR_LOAD   = 3'd0;
    localparam logic [2:0] VAR_RSHIFT = 3'd4;

    // operation codes
    localparam logic [3:0] OP_LOAD   = 4'd0;
    localparam logic [3:0] OP_STORE  = 4'd1;
    localparam logic [3:0] OP_LOADI  = 4'd2;
    localparam logic [3:0] OP_ADD    = 4'd3;
    localparam logic [3:0] OP_RSHIFT = 4'd7;
    localparam logic [3:0] OP_OUTPUT = 4'd8;
    localparam logic [3:0] OP_NOP    = 4'd9;

    // record kinds
    localparam logic [1:0] KIND_INSTR   = 2'd0;
    localparam logic [1:0] KIND_END_OK  = 2'd1;
    localparam logic [1:0] KIND_END_ERR = 2'd2;

    // grammar positions
    localparam logic [3:0] P_START    = 4'd0;
    localparam logic [3:0] P_MEM_R1   = 4'd1;
    localparam logic [3:0] P_LDI_C    = 4'd2;
    localparam logic [3:0] P_AR_R1    = 4'd3;
    localparam logic [3:0] P_AR_COMMA = 4'd4;
    localparam logic [3:0] P_AR_R2    = 4'd5;
    localparam logic [3:0] P_ARROW    = 4'd6;
    localparam logic [3:0] P_DEST     = 4'd7;
    localparam logic [3:0] P_OUT_C    = 4'd8;
    localparam logic [3:0] P_END      = 4'd9;

    typedef struct packed {
        logic [3:0]                   pos;
        logic [3:0]                   opc;
        logic signed [VALUE_BITS-1:0] first;
        logic signed [VALUE_BITS-1:0] second;
        logic signed [VALUE_BITS-1:0] third;
        logic [LINE_BITS-1:0]         line;
        logic [COUNT_BITS-1:0]        count;
        logic [REG_BITS-1:0]          max_reg;
        logic                         ok;
    } st_t;

    localparam st_t ST_RESET = '{ok: 1'b1, default: '0};

    typedef struct packed {
        logic [1:0]                   kind;
        logic [LINE_BITS-1:0]         line;
        logic [3:0]                   opc;
        logic signed [VALUE_BITS-1:0] op_one;
        logic signed [VALUE_BITS-1:0] op_two;
        logic signed [VALUE_BITS-1:0] op_three;
        logic [COUNT_BITS-1:0]        total;
        logic [REG_BITS-1:0]          largest;
        logic                         last;
    } rec_t;

endpackage

`default_nettype wire

@@ sv/ilr_step.sv @@
// Next-state and record logic for one token of the ILOC line recognizer.
// Depends on ilr_pkg.
`default_nettype none

module ilr_step
    import ilr_pkg::*;
(
    input  st_t                  st,
    input  logic [3:0]           token_category,
    input  logic [2:0]           token_variant,
    input  logic [REG_BITS-1:0]  token_value,
    input  logic [LINE_BITS-1:0] token_line,
    output st_t                  nxt,
    output rec_t                 rec0,
    output rec_t                 rec1,
    output logic [1:0]           num
);

    logic [3:0]            pos;
    logic [VALUE_BITS-1:0] val_ext;
    logic                  tok_ok;
    logic                  emit_inst;
    logic                  emit_end;
    logic [REG_BITS-1:0]   m;
    st_t                   nx;
    rec_t                  instr;
    rec_t                  endr;

    always_comb
    begin
        pos       = (st.pos > P_END) ? P_START : st.pos;
        val_ext   = {1'b0, token_value};
        nx        = st;
        tok_ok    = 1'b1;
        emit_inst = 1'b0;
        emit_end  = 1'b0;
        m         = st.max_reg;
        instr     = '0;
        endr      = '0;

        if (pos == P_START)
        begin
            nx.line = token_line;
            unique case (token_category)
                CAT_MEMOP:
                begin
                    nx.opc = (token_variant == VAR_LOAD) ? OP_LOAD : OP_STORE;
                    nx.pos = P_MEM_R1;
                end
                CAT_LOADI:
                begin
                    nx.opc = OP_LOADI;
                    nx.pos = P_LDI_C;
                end
                CAT_ARITH:
                begin
                    nx.opc = (token_variant > VAR_RSHIFT) ? OP_RSHIFT
                                                          : OP_ADD + {1'b0, token_variant};
                    nx.pos = P_AR_R1;
                end
                CAT_OUTPUT:
                begin
                    nx.opc = OP_OUTPUT;
                    nx.pos = P_OUT_C;
                end
                CAT_NOP:
                begin
                    nx.opc    = OP_NOP;
                    nx.first  = '1;
                    nx.second = '1;
                    nx.third  = '1;
                    nx.pos    = P_END;
                end
                CAT_EOF:     emit_end = 1'b1;
                CAT_NEWLINE: nx.pos = P_START;
                default:     tok_ok = 1'b0;
            endcase
        end
        else
        begin
            tok_ok = 1'b0;
            unique case (pos)
                P_MEM_R1, P_LDI_C:
                begin
                    if (token_category == ((pos == P_MEM_R1) ? CAT_REGISTER : CAT_CONST))
                    begin
                        nx.first  = val_ext;
                        nx.second = '1;
                        nx.pos    = P_ARROW;
                        tok_ok    = 1'b1;
                    end
                end
                P_AR_R1:
                begin
                    if (token_category == CAT_REGISTER)
                    begin
                        nx.first = val_ext;
                        nx.pos   = P_AR_COMMA;
                        tok_ok   = 1'b1;
                    end
                end
                P_AR_COMMA:
                begin
                    if (token_category == CAT_COMMA)
                    begin
                        nx.pos = P_AR_R2;
                        tok_ok = 1'b1;
                    end
                end
                P_AR_R2:
                begin
                    if (token_category == CAT_REGISTER)
                    begin
                        nx.second = val_ext;
                        nx.pos    = P_ARROW;
                        tok_ok    = 1'b1;
                    end
                end
                P_ARROW:
                begin
                    if (token_category == CAT_ARROW)
                    begin
                        nx.pos = P_DEST;
                        tok_ok = 1'b1;
                    end
                end
                P_DEST:
                begin
                    if (token_category == CAT_REGISTER)
                    begin
                        nx.third = val_ext;
                        nx.pos   = P_END;
                        tok_ok   = 1'b1;
                    end
                end
                P_OUT_C:
                begin
                    if (token_category == CAT_CONST)
                    begin
                        nx.first  = val_ext;
                        nx.second = '1;
                        nx.third  = '1;
                        nx.pos    = P_END;
                        tok_ok    = 1'b1;
                    end
                end
                default:
                begin
                    if (token_category == CAT_EOF || token_category == CAT_NEWLINE)
                    begin
                        tok_ok    = 1'b1;
                        emit_inst = 1'b1;
                        if (st.count != COUNT_MAX)
                            nx.count = st.count + 1'b1;
                        if (st.opc == OP_LOADI)
                        begin
                            if (!st.third[VALUE_BITS-1] && st.third[REG_BITS-1:0] > m)
                                m = st.third[REG_BITS-1:0];
                        end
                        else if (st.opc < OP_OUTPUT)
                        begin
                            if (!st.first[VALUE_BITS-1] && st.first[REG_BITS-1:0] > m)
                                m = st.first[REG_BITS-1:0];
                            if (!st.second[VALUE_BITS-1] && st.second[REG_BITS-1:0] > m)
                                m = st.second[REG_BITS-1:0];
                            if (!st.third[VALUE_BITS-1] && st.third[REG_BITS-1:0] > m)
                                m = st.third[REG_BITS-1:0];
                        end
                        nx.max_reg     = m;
                        instr.kind     = KIND_INSTR;
                        instr.line     = st.line;
                        instr.opc      = st.opc;
                        instr.op_one   = st.first;
                        instr.op_two   = st.second;
                        instr.op_three = st.third;
                        instr.total    = nx.count;
                        instr.largest  = m;
                        nx.pos         = P_START;
                        emit_end       = (token_category == CAT_EOF);
                    end
                end
            endcase
        end

        if (!tok_ok)
        begin
            nx.ok  = 1'b0;
            nx.pos = P_START;
            if (token_category == CAT_EOF)
                emit_end = 1'b1;
        end

        if (emit_end)
        begin
            endr.kind     = nx.ok ? KIND_END_OK : KIND_END_ERR;
            endr.op_one   = '1;
            endr.op_two   = '1;
            endr.op_three = '1;
            endr.total    = nx.count;
            endr.largest  = nx.max_reg;
            endr.last     = 1'b1;
            nx            = ST_RESET;
        end

        instr.last = !emit_end;
        nxt  = nx;
        rec0 = emit_inst ? instr : endr;
        rec1 = endr;
        num  = {1'b0, emit_inst} + {1'b0, emit_end};
    end

endmodule

`default_nettype wire

@@ sv/iloc_line_recognizer_unit.sv @@
// Top level of the ILOC line recognizer: token stream in, instruction records out.
// Depends on ilr_pkg and ilr_step.
`default_nettype none

// The unit takes one scanner token per cycle and updates its grammar state in the
// same cycle; each token yields zero, one or two records (instruction, end of file,
// or both), written into a three-entry output queue. A token is taken whenever at
// most one record is waiting, so with a ready consumer the rate is one token per
// clock; a line ended by end of file leaves the consumer a second record to drain.
// Records are registered in the queue before they reach the output.
// After each end record all counters and flags return to their reset values.

module iloc_line_recognizer_unit
    import ilr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // token_value, token_line, zero fill
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // token_category, token_variant
    input  logic [IN_USER_BITS-1:0]  s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // record_line, operation_code, operand_one, operand_two, operand_three,
    // operation_total, largest_register, zero fill
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // record_kind
    output logic [1:0]               m_axis_tuser,
    output logic                     m_axis_tlast
);

    st_t        st_reg;
    st_t        st_next;
    rec_t       rec0;
    rec_t       rec1;
    logic [1:0] num;
    rec_t       q_reg [3];
    rec_t       q_next [3];
    rec_t       sh [3];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic [1:0] cnt_after;
    logic       accept;
    logic       pop;

    ilr_step u_step (
        .st             (st_reg),
        .token_category (s_axis_tuser[3:0]),
        .token_variant  (s_axis_tuser[6:4]),
        .token_value    (s_axis_tdata[REG_BITS-1:0]),
        .token_line     (s_axis_tdata[REG_BITS+LINE_BITS-1:REG_BITS]),
        .nxt            (st_next),
        .rec0           (rec0),
        .rec1           (rec1),
        .num            (num)
    );

    assign s_axis_tready = (cnt_reg <= 2'd1);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = (cnt_reg != 2'd0) && m_axis_tready;

    always_comb
    begin
        sh[0]     = pop ? q_reg[1] : q_reg[0];
        sh[1]     = pop ? q_reg[2] : q_reg[1];
        sh[2]     = q_reg[2];
        cnt_after = cnt_reg - {1'b0, pop};
        cnt_next  = cnt_after + (accept ? num : 2'd0);
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < cnt_after)
                q_next[i] = sh[i];
            else if (2'(i) == cnt_after)
                q_next[i] = rec0;
            else
                q_next[i] = rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_RESET;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (accept)
                st_reg <= st_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            q_reg[i] <= q_next[i];
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tuser  = q_reg[0].kind;
    assign m_axis_tlast  = q_reg[0].last;
    assign m_axis_tdata  = OUT_DATA_BITS'({q_reg[0].largest, q_reg[0].total,
                                           q_reg[0].op_three, q_reg[0].op_two,
                                           q_reg[0].op_one, q_reg[0].opc,
                                           q_reg[0].line});

endmodule

`default_nettype wire

@@ sv/ilr_checker.sv @@
// Port-level checks for the ILOC line recognizer, bound to its top level.
// Depends on ilr_pkg.
`default_nettype none

module ilr_checker
    import ilr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_axis_tready,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [1:0]               m_axis_tuser,
    input logic                     m_axis_tlast
);

    localparam int OPC_LO = LINE_BITS;
    localparam int ONE_LO = LINE_BITS + 4;
    localparam int TWO_LO = ONE_LO + VALUE_BITS;
    localparam int THR_LO = TWO_LO + VALUE_BITS;

    // hold a stalled record
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled record changed");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("bad record kind");

    a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_INSTR |->
            m_axis_tlast && m_axis_tdata[LINE_BITS+3:0] == '0
            && m_axis_tdata[TWO_LO-1:ONE_LO] == '1
            && m_axis_tdata[THR_LO-1:TWO_LO] == '1
            && m_axis_tdata[THR_LO+VALUE_BITS-1:THR_LO] == '1)
        else $error("malformed end record");

    a_instr_opc: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_INSTR |->
            m_axis_tdata[OPC_LO+3:OPC_LO] <= OP_NOP)
        else $error("bad operation code");

    // accept tokens whenever no record is waiting
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind iloc_line_recognizer_unit ilr_checker u_ilr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
